// ----- rtl/lfn_pkg.sv -----
// Package: formats, payload types and stage records for the narrowing pipeline.
package lfn_pkg;

  typedef enum logic [1:0] {
    FMT_HALF   = 2'd0,
    FMT_SINGLE = 2'd1,
    FMT_DOUBLE = 2'd2
  } fmt_t;

  // first stage record: double to single attempt
  typedef struct packed {
    logic        ok;
    logic [31:0] bits;
    logic [63:0] orig;
  } s1_t;

  // second stage record: final choice
  typedef struct packed {
    fmt_t        fmt;
    logic [63:0] bits;
  } res_t;

endpackage

// ----- rtl/lossless_float_narrowing.sv -----
// Top level: three-stage pipeline narrowing binary64 to the shortest exact format.
// Stages: input, single, half/output.
// Throughput: one item per cycle; the whole pipeline advances when the output slot
// is free or being taken, so a stall holds every stage and loses nothing.
// Reset: rst (synchronous) clears all valid bits and sets allow_half to 1.
module lossless_float_narrowing import lfn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,       // allow_half
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,        // [63:0] double_bits
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata         // [1:0] result_format, [65:2] result_bits, zero pad
);
  logic        allow_half;
  logic [63:0] in_reg;
  logic [2:0]  vld;
  logic        adv;
  s1_t         s1;
  res_t        s2;

  // advance everything when the last slot is empty or being drained
  assign adv      = !vld[2] || m_tready;
  assign s_tready = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld        <= '0;
      allow_half <= 1'b1;
    end else begin
      if (cfg_valid) allow_half <= cfg_data;
      if (adv) vld <= {vld[1:0], s_tvalid};
    end
  end

  // register the incoming item
  always_ff @(posedge clk) begin
    if (adv) in_reg <= s_tdata;
  end

  lfn_d2s u_d2s (.clk(clk), .en(adv), .x(in_reg), .q(s1));
  lfn_s2h u_s2h (.clk(clk), .en(adv), .allow_half(allow_half), .a(s1), .q(s2));

  assign m_tvalid = vld[2];
  assign m_tdata  = {6'd0, s2.bits, s2.fmt};

  // a stalled result holds its valid
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped under stall");
  // accepted items pass the input, single and half/output stages to the output while m_tready stays high
  a_pipe: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && m_tready ##1 m_tready ##1 m_tready |=> m_tvalid)
    else $error("item lost in pipeline");
  // half results are right-aligned in 16 bits
  a_half: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && s2.fmt == FMT_HALF |-> s2.bits[63:16] == '0)
    else $error("half result not aligned");
endmodule

// ----- rtl/lfn_d2s.sv -----
// Double to single exact narrowing, one registered stage.
module lfn_d2s import lfn_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] x,
  output s1_t         q
);
  logic        sign;
  logic [10:0] bexp;
  logic [51:0] frac;
  logic [52:0] full;
  logic [5:0]  shift;
  logic [52:0] lowm;
  s1_t         d;

  assign sign = x[63];
  assign bexp = x[62:52];
  assign frac = x[51:0];
  assign full = {1'b1, frac};
  // subnormal shift = (-126 - e) + 29 with e = bexp - 1023, so 926 - bexp
  assign shift = 6'(11'd926 - bexp);
  assign lowm  = (53'd1 << shift) - 53'd1;

  always_comb begin
    d.ok   = 1'b0;
    d.bits = '0;
    d.orig = x;
    if (bexp == 11'd0) begin
      d.ok   = (frac == '0);
      d.bits = {sign, 31'd0};
    end else if (bexp == 11'h7ff) begin
      d.ok   = (frac[28:0] == '0);
      d.bits = {sign, 8'hff, frac[51:29]};
    end else if (bexp >= 11'd897 && bexp <= 11'd1150) begin
      d.ok   = (frac[28:0] == '0);
      d.bits = {sign, 8'(bexp - 11'd896), frac[51:29]};
    end else if (bexp < 11'd897 && bexp >= 11'd874) begin
      // shift in 30..52
      d.ok   = ((full & lowm) == '0);
      d.bits = {sign, 31'(full >> shift)};
    end
  end

  always_ff @(posedge clk) begin
    if (en) q <= d;
  end
endmodule

// ----- rtl/lfn_s2h.sv -----
// Single to half exact narrowing and final selection, one registered stage.
module lfn_s2h import lfn_pkg::*; (
  input  logic clk,
  input  logic en,
  input  logic allow_half,
  input  s1_t  a,
  output res_t q
);
  logic        sign;
  logic [7:0]  bexp;
  logic [22:0] frac;
  logic [23:0] full;
  logic [4:0]  shift;
  logic [23:0] lowm;
  logic        hok;
  logic [15:0] hb;
  res_t        d;

  assign sign  = a.bits[31];
  assign bexp  = a.bits[30:23];
  assign frac  = a.bits[22:0];
  assign full  = {1'b1, frac};
  assign shift = 5'(8'd126 - bexp);
  assign lowm  = (24'd1 << shift) - 24'd1;

  always_comb begin
    hok = 1'b0;
    hb  = '0;
    if (bexp == 8'd0) begin
      hok = (frac == '0);
      hb  = {sign, 15'd0};
    end else if (bexp == 8'hff) begin
      hok = (frac[12:0] == '0);
      hb  = {sign, 5'h1f, frac[22:13]};
    end else if (bexp >= 8'd113 && bexp <= 8'd142) begin
      hok = (frac[12:0] == '0);
      hb  = {sign, 5'(bexp - 8'd112), frac[22:13]};
    end else if (bexp < 8'd113 && bexp >= 8'd103) begin
      // shift in 14..23
      hok = ((full & lowm) == '0);
      hb  = {sign, 15'(full >> shift)};
    end
    if (!a.ok) begin
      d.fmt  = FMT_DOUBLE;
      d.bits = a.orig;
    end else if (allow_half && hok) begin
      d.fmt  = FMT_HALF;
      d.bits = {48'd0, hb};
    end else begin
      d.fmt  = FMT_SINGLE;
      d.bits = {32'd0, a.bits};
    end
  end

  always_ff @(posedge clk) begin
    if (en) q <= d;
  end
endmodule
